>>> rtl/tge_pkg.sv
// ----------------------------------------------------------------------------
// tge_pkg
// Shared types and constants for the turtle graphics engine: command codes,
// angle and position limits, CORDIC gain and arctangent table.
// ----------------------------------------------------------------------------
package tge_pkg;

	typedef enum logic [3:0] {
		OP_FORWARD  = 4'd0,
		OP_BACK     = 4'd1,
		OP_LEFT     = 4'd2,
		OP_RIGHT    = 4'd3,
		OP_PEN_UP   = 4'd4,
		OP_PEN_DOWN = 4'd5,
		OP_SET_POS  = 4'd6,
		OP_HOME     = 4'd7,
		OP_QUERY    = 4'd8
	} op_t;

	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam int FULL_TURN    = 92160;
	localparam int QUARTER_TURN = 23040;

	localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] POS_MIN = -24'sh800000;

	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	// arctan(2^-i) in degrees, Q.24
	function automatic logic signed [32:0] atan_q24(input logic [4:0] i);
		logic signed [32:0] r;
		case (i)
			5'd0:  r = 33'sd754974720;
			5'd1:  r = 33'sd445687602;
			5'd2:  r = 33'sd235489088;
			5'd3:  r = 33'sd119537938;
			5'd4:  r = 33'sd60000934;
			5'd5:  r = 33'sd30029717;
			5'd6:  r = 33'sd15018523;
			5'd7:  r = 33'sd7509720;
			5'd8:  r = 33'sd3754917;
			5'd9:  r = 33'sd1877466;
			5'd10: r = 33'sd938734;
			5'd11: r = 33'sd469367;
			5'd12: r = 33'sd234683;
			5'd13: r = 33'sd117342;
			5'd14: r = 33'sd58671;
			5'd15: r = 33'sd29335;
			5'd16: r = 33'sd14668;
			5'd17: r = 33'sd7334;
			5'd18: r = 33'sd3667;
			5'd19: r = 33'sd1833;
			5'd20: r = 33'sd917;
			5'd21: r = 33'sd458;
			5'd22: r = 33'sd229;
			5'd23: r = 33'sd115;
			5'd24: r = 33'sd57;
			5'd25: r = 33'sd29;
			5'd26: r = 33'sd14;
			5'd27: r = 33'sd7;
			5'd28: r = 33'sd4;
			5'd29: r = 33'sd2;
			5'd30: r = 33'sd1;
			default: r = 33'sd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/tge_cordic.sv
// ----------------------------------------------------------------------------
// tge_cordic
// Iterative CORDIC rotation: one shift-add iteration per cycle over a
// quadrant-reduced heading, then quadrant mapping to cos and sin in Q.30.
// ----------------------------------------------------------------------------
module tge_cordic #(
	parameter int STEPS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [16:0]        heading,
	output logic               done,
	output logic signed [32:0] cos_val,
	output logic signed [32:0] sin_val
);

	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic signed [32:0] x_q, y_q, z_q;
	logic [1:0]         quad_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q, done_q;

	logic [1:0]         quad_w;
	logic [16:0]        rem_w;
	logic signed [32:0] xs_w, ys_w, atan_w;

	always_comb begin
		if (heading >= 17'(3 * tge_pkg::QUARTER_TURN)) begin
			quad_w = 2'd3;
			rem_w  = heading - 17'(3 * tge_pkg::QUARTER_TURN);
		end else if (heading >= 17'(2 * tge_pkg::QUARTER_TURN)) begin
			quad_w = 2'd2;
			rem_w  = heading - 17'(2 * tge_pkg::QUARTER_TURN);
		end else if (heading >= 17'(tge_pkg::QUARTER_TURN)) begin
			quad_w = 2'd1;
			rem_w  = heading - 17'(tge_pkg::QUARTER_TURN);
		end else begin
			quad_w = 2'd0;
			rem_w  = heading;
		end
	end

	assign xs_w   = x_q >>> 5'(cnt_q);
	assign ys_w   = y_q >>> 5'(cnt_q);
	assign atan_w = tge_pkg::atan_q24(5'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= tge_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= 33'({rem_w, 16'h0000});
			quad_q <= quad_w;
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys_w;
				y_q <= y_q + xs_w;
				z_q <= z_q - atan_w;
			end else begin
				x_q <= x_q + ys_w;
				y_q <= y_q - xs_w;
				z_q <= z_q + atan_w;
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_val = x_q;
				sin_val = y_q;
			end
			2'd1: begin
				cos_val = -y_q;
				sin_val = x_q;
			end
			2'd2: begin
				cos_val = -x_q;
				sin_val = -y_q;
			end
			default: begin
				cos_val = y_q;
				sin_val = -x_q;
			end
		endcase
	end

	assign done = done_q;

endmodule

>>> rtl/tge_wrap.sv
// ----------------------------------------------------------------------------
// tge_wrap
// Iterative reduction of a heading into [0, 360) degrees: offset into the
// positive range, then eight conditional subtractions of scaled full turns.
// ----------------------------------------------------------------------------
module tge_wrap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [25:0] value,
	output logic               done,
	output logic [16:0]        result
);

	localparam logic [25:0] OFFSET = 26'(tge_pkg::FULL_TURN * 128);

	logic [25:0] v_q;
	logic [2:0]  k_q;
	logic        busy_q, done_q;
	logic [25:0] turn_w;

	assign turn_w = 26'(tge_pkg::FULL_TURN) << k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			k_q    <= 3'd7;
		end else if (busy_q) begin
			k_q <= k_q - 1'b1;
			if (k_q == 3'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= $unsigned(value) + OFFSET;
		end else if (busy_q && v_q >= turn_w) begin
			v_q <= v_q - turn_w;
		end
	end

	assign done   = done_q;
	assign result = v_q[16:0];

endmodule

>>> rtl/turtle_graphics_engine_top.sv
// ----------------------------------------------------------------------------
// turtle_graphics_engine_top
// Turtle graphics engine: position, heading and pen state driven by a command
// stream, one result item per command.
// ----------------------------------------------------------------------------
// The block takes one command at a time and returns one result item for it.
// Forward and back run the CORDIC unit, one rotation iteration per cycle, then
// one shared multiplier scales cos and then sin by the distance. Left, right
// and set position wait for the eight-step heading reduction. Pen, home and
// query commands go straight to the finish state. A finished result waits in
// the output register while the next command is already being worked on.
// ----------------------------------------------------------------------------
module turtle_graphics_engine_top #(
	parameter int CORDIC_STEPS = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [14:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// amount[23:0], pos_x[47:24], pos_y[71:48]
	input  logic [71:0]  s_tdata,
	// operation[3:0]
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// line_x0[15:0], line_y0[31:16], line_x1[47:32], line_y1[63:48],
	// cur_x[87:64], cur_y[111:88], cur_heading[128:112], pen_is_down[129],
	// zero[135:130]
	output logic [135:0] m_tdata,
	// draw[0]
	output logic         m_tuser
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_WRAP = 6'b000010,
		ST_ROT  = 6'b000100,
		ST_MULC = 6'b001000,
		ST_MULS = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	function automatic logic signed [23:0] sat_add(input logic signed [23:0] pos,
	                                               input logic signed [57:0] prod);
		logic signed [57:0] t;
		logic signed [28:0] s;
		logic signed [23:0] r;
		t = prod + (58'sd1 <<< 29);
		s = 29'(pos) + 29'(signed'(t[57:30]));
		if (s > 29'(tge_pkg::POS_MAX)) begin
			r = tge_pkg::POS_MAX;
		end else if (s < 29'(tge_pkg::POS_MIN)) begin
			r = tge_pkg::POS_MIN;
		end else begin
			r = s[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] trunc_pixel(input logic signed [23:0] v);
		logic [23:0] mag;
		logic [15:0] m;
		mag = v[23] ? -v : v;
		m   = mag[23:8];
		return v[23] ? -m : m;
	endfunction

	state_t             state_q;
	tge_pkg::op_t       op_q;
	logic signed [23:0] amount_q, px_q, py_q;
	logic signed [23:0] x_q, y_q;
	logic [16:0]        heading_q;
	logic               pen_q;
	logic [14:0]        width_q, height_q;
	logic signed [57:0] prod_q;
	logic signed [15:0] lx0_q;
	logic [135:0]       out_data_q;
	logic               out_draw_q, m_tvalid_q;

	logic               accept, out_free, fin_fire;
	tge_pkg::op_t       s_op;
	logic signed [23:0] s_amount;
	logic               cordic_start, cordic_done;
	logic signed [32:0] cos_w, sin_w, trig_w;
	logic               wrap_start, wrap_done;
	logic signed [25:0] wrap_in;
	logic [16:0]        wrap_res;
	logic signed [24:0] dist_w;
	logic signed [57:0] mul_w;

	logic signed [23:0] nx, ny;
	logic [16:0]        nh;
	logic               npen, ndraw;
	logic signed [15:0] lx0, ly0, lx1, ly1;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign fin_fire = (state_q == ST_FIN) && out_free;
	assign s_op     = tge_pkg::op_t'(s_tuser);
	assign s_amount = signed'(s_tdata[23:0]);

	assign cordic_start = accept && (s_op == tge_pkg::OP_FORWARD || s_op == tge_pkg::OP_BACK);
	assign wrap_start   = accept && (s_op == tge_pkg::OP_LEFT || s_op == tge_pkg::OP_RIGHT ||
	                                 s_op == tge_pkg::OP_SET_POS);

	always_comb begin
		case (s_op)
			tge_pkg::OP_LEFT:  wrap_in = 26'(signed'({1'b0, heading_q})) - 26'(s_amount);
			tge_pkg::OP_RIGHT: wrap_in = 26'(signed'({1'b0, heading_q})) + 26'(s_amount);
			default:           wrap_in = 26'(s_amount);
		endcase
	end

	tge_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.heading (heading_q),
		.done    (cordic_done),
		.cos_val (cos_w),
		.sin_val (sin_w)
	);

	tge_wrap u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wrap_start),
		.value  (wrap_in),
		.done   (wrap_done),
		.result (wrap_res)
	);

	assign dist_w = (op_q == tge_pkg::OP_BACK) ? -(25'(amount_q)) : 25'(amount_q);
	assign trig_w = (state_q == ST_MULC) ? cos_w : sin_w;
	assign mul_w  = trig_w * dist_w;

	always_comb begin
		nx    = x_q;
		ny    = y_q;
		nh    = heading_q;
		npen  = pen_q;
		ndraw = 1'b0;
		case (op_q)
			tge_pkg::OP_FORWARD, tge_pkg::OP_BACK: begin
				ny    = sat_add(y_q, prod_q);
				ndraw = pen_q;
			end
			tge_pkg::OP_LEFT, tge_pkg::OP_RIGHT: nh = wrap_res;
			tge_pkg::OP_PEN_UP:   npen = 1'b0;
			tge_pkg::OP_PEN_DOWN: npen = 1'b1;
			tge_pkg::OP_SET_POS: begin
				nx = px_q;
				ny = py_q;
				nh = wrap_res;
			end
			tge_pkg::OP_HOME: begin
				nx   = 24'({width_q[14:1], 8'h00});
				ny   = 24'({height_q[14:1], 8'h00});
				nh   = '0;
				npen = 1'b1;
			end
			default: ;
		endcase
		lx0 = ndraw ? lx0_q : '0;
		ly0 = ndraw ? trunc_pixel(y_q) : '0;
		lx1 = ndraw ? trunc_pixel(x_q) : '0;
		ly1 = ndraw ? trunc_pixel(ny) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 15'd320;
			height_q <= 15'd200;
		end else if (cfg_we) begin
			case (cfg_index)
				tge_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				tge_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			x_q        <= '0;
			y_q        <= '0;
			heading_q  <= '0;
			pen_q      <= 1'b0;
		end else begin
			if (m_tready && !fin_fire) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cordic_start) begin
							state_q <= ST_ROT;
						end else if (wrap_start) begin
							state_q <= ST_WRAP;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_WRAP: begin
					if (wrap_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_ROT: begin
					if (cordic_done) begin
						state_q <= ST_MULC;
					end
				end
				ST_MULC: state_q <= ST_MULS;
				ST_MULS: begin
					x_q     <= sat_add(x_q, prod_q);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						x_q        <= nx;
						y_q        <= ny;
						heading_q  <= nh;
						pen_q      <= npen;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= s_op;
			amount_q <= s_amount;
			px_q     <= signed'(s_tdata[47:24]);
			py_q     <= signed'(s_tdata[71:48]);
		end
		if (state_q == ST_MULC || state_q == ST_MULS) begin
			prod_q <= mul_w;
		end
		if (state_q == ST_MULS) begin
			lx0_q <= trunc_pixel(x_q);
		end
		if (fin_fire) begin
			out_draw_q <= ndraw;
			out_data_q <= {6'b000000, npen, nh, ny, nx, ly1, lx1, ly0, lx0};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_draw_q;

endmodule

>>> bench/turtle_graphics_engine_top_tb.sv
// ----------------------------------------------------------------------------
// turtle_graphics_engine_top_tb
// Self-checking bench for the turtle graphics engine. A queue of commands
// feeds a bursty stream driver. Each accepted command runs through a local
// turtle model (CORDIC heading, Q16.8 position with saturation, pen state).
// The model's prediction is compared field by field with the result stream,
// which stalls on its own pattern. Screen size registers are changed
// between phases, extremes included.
// ----------------------------------------------------------------------------
module turtle_graphics_engine_top_tb;

	typedef struct {
		logic [3:0]         op;
		logic signed [23:0] amount;
		logic signed [23:0] px;
		logic signed [23:0] py;
	} cmd_t;

	typedef struct {
		bit     draw;
		longint x0;
		longint y0;
		longint x1;
		longint y1;
		longint cx;
		longint cy;
		longint hd;
		bit     pen;
	} res_t;

	localparam int     TRIG_STEPS = 20;
	localparam longint DEG360     = 92160;
	localparam longint DEG90      = 23040;
	localparam longint TRIG_GAIN  = 652032874;
	localparam longint Q_HI       = 8388607;
	localparam longint Q_LO       = -8388608;

	localparam logic signed [23:0] AMT_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] AMT_MIN = 24'sh800000;

	localparam logic [3:0] OP_SPARE_LO = 4'd9;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;
	localparam logic [1:0] REG_SPARE   = 2'd3;

	localparam int STALL_LIMIT   = 4000;
	localparam int ITEMS_PER_RUN = 290;
	localparam int MAX_PRINTS    = 40;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [14:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;
	logic [3:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic         m_tuser;

	longint atan_deg [TRIG_STEPS] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234683,
		117342, 58671, 29335, 14668, 7334, 3667, 1833
	};

	longint t_x = 0;
	longint t_y = 0;
	longint t_head = 0;
	bit     t_pen = 1'b0;
	longint scr_w = 320;
	longint scr_h = 200;

	cmd_t   cmd_queue [$];
	res_t   expected_results [$];
	cmd_t   drv_cmd;
	int     burst_left;
	int     gap_left;
	int unsigned rx_tick;
	int     rx_hold;
	int     idle_cycles;
	int     err_count = 0;
	int     results_seen = 0;

	turtle_graphics_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint wrap_deg(input longint v);
		longint r;
		r = v % DEG360;
		if (r < 0)
			r = r + DEG360;
		return r;
	endfunction

	function automatic longint clamp_pos(input longint v);
		if (v > Q_HI)
			return Q_HI;
		if (v < Q_LO)
			return Q_LO;
		return v;
	endfunction

	function automatic longint scale_q30(input longint trig, input longint mv_len);
		return (trig * mv_len + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint trunc_px(input longint v);
		if (v >= 0)
			return v >>> 8;
		return -((-v) >>> 8);
	endfunction

	function automatic res_t advance_turtle(input cmd_t c);
		res_t   r;
		longint amt, mv_len, cs, sn, ox, oy, q, z, vx, vy, xs, ys;
		amt = c.amount;
		r = '{default: 0};
		case (c.op)
			tge_pkg::OP_FORWARD, tge_pkg::OP_BACK: begin
				mv_len = (c.op == tge_pkg::OP_BACK) ? -amt : amt;
				q = t_head / DEG90;
				z = (t_head % DEG90) * 65536;
				vx = TRIG_GAIN;
				vy = 0;
				for (int i = 0; i < TRIG_STEPS; i++) begin
					xs = vx >>> i;
					ys = vy >>> i;
					if (z >= 0) begin
						vx = vx - ys;
						vy = vy + xs;
						z = z - atan_deg[i];
					end else begin
						vx = vx + ys;
						vy = vy - xs;
						z = z + atan_deg[i];
					end
				end
				case (q)
					0: begin cs = vx;  sn = vy;  end
					1: begin cs = -vy; sn = vx;  end
					2: begin cs = -vx; sn = -vy; end
					default: begin cs = vy; sn = -vx; end
				endcase
				ox = t_x;
				oy = t_y;
				t_x = clamp_pos(t_x + scale_q30(cs, mv_len));
				t_y = clamp_pos(t_y + scale_q30(sn, mv_len));
				if (t_pen) begin
					r.draw = 1'b1;
					r.x0 = trunc_px(ox);
					r.y0 = trunc_px(oy);
					r.x1 = trunc_px(t_x);
					r.y1 = trunc_px(t_y);
				end
			end
			tge_pkg::OP_LEFT:     t_head = wrap_deg(t_head - amt);
			tge_pkg::OP_RIGHT:    t_head = wrap_deg(t_head + amt);
			tge_pkg::OP_PEN_UP:   t_pen = 1'b0;
			tge_pkg::OP_PEN_DOWN: t_pen = 1'b1;
			tge_pkg::OP_SET_POS: begin
				t_x = c.px;
				t_y = c.py;
				t_head = wrap_deg(amt);
			end
			tge_pkg::OP_HOME: begin
				t_x = (scr_w >> 1) << 8;
				t_y = (scr_h >> 1) << 8;
				t_head = 0;
				t_pen = 1'b1;
			end
			default: ;
		endcase
		r.cx = t_x;
		r.cy = t_y;
		r.hd = t_head;
		r.pen = t_pen;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (err_count < MAX_PRINTS)
			$display("mismatch at result %0d: %s got %0d want %0d",
				results_seen, what, got, want);
		err_count++;
	endtask

	task automatic compare_field(input string what, input longint got, input longint want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	task automatic add_cmd(input logic [3:0] op, input logic signed [23:0] amt,
			input logic signed [23:0] px, input logic signed [23:0] py);
		cmd_t c;
		c.op = op;
		c.amount = amt;
		c.px = px;
		c.py = py;
		cmd_queue.push_back(c);
	endtask

	function automatic cmd_t rand_cmd();
		cmd_t        c;
		int unsigned pick;
		int          v;
		pick = $urandom_range(0, 99);
		c.amount = 24'($urandom);
		c.px = 24'($urandom);
		c.py = 24'($urandom);
		if (pick < 22)
			c.op = tge_pkg::OP_FORWARD;
		else if (pick < 40)
			c.op = tge_pkg::OP_BACK;
		else if (pick < 52)
			c.op = tge_pkg::OP_LEFT;
		else if (pick < 64)
			c.op = tge_pkg::OP_RIGHT;
		else if (pick < 72)
			c.op = tge_pkg::OP_PEN_UP;
		else if (pick < 82)
			c.op = tge_pkg::OP_PEN_DOWN;
		else if (pick < 92)
			c.op = tge_pkg::OP_SET_POS;
		else if (pick < 95)
			c.op = tge_pkg::OP_HOME;
		else if (pick < 97)
			c.op = tge_pkg::OP_QUERY;
		else
			c.op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if ((c.op == tge_pkg::OP_FORWARD || c.op == tge_pkg::OP_BACK) &&
				$urandom_range(0, 99) < 85) begin
			v = int'($urandom_range(0, 32768)) - 16384;
			c.amount = v[23:0];
		end
		if ((c.op == tge_pkg::OP_LEFT || c.op == tge_pkg::OP_RIGHT) &&
				$urandom_range(0, 99) < 70) begin
			v = int'($urandom_range(0, 368640)) - 184320;
			c.amount = v[23:0];
		end
		if (c.op == tge_pkg::OP_SET_POS && $urandom_range(0, 99) < 75) begin
			v = int'($urandom_range(0, 204800)) - 102400;
			c.px = v[23:0];
			v = int'($urandom_range(0, 204800)) - 102400;
			c.py = v[23:0];
		end
		return c;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tge_pkg::REG_SCREEN_WIDTH)
			scr_w = val;
		else if (idx == tge_pkg::REG_SCREEN_HEIGHT)
			scr_h = val;
	endtask

	task automatic wait_idle();
		while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin : drive
			cmd_t nxt_cmd;
			if (s_tvalid && s_tready)
				expected_results.push_back(advance_turtle(drv_cmd));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() != 0) begin
					nxt_cmd = cmd_queue.pop_front();
					drv_cmd <= nxt_cmd;
					s_tvalid <= 1'b1;
					s_tdata <= {nxt_cmd.py, nxt_cmd.px, nxt_cmd.amount};
					s_tuser <= nxt_cmd.op;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						if ($urandom_range(0, 9) < 4)
							gap_left <= 0;
						else if ($urandom_range(0, 7) == 0)
							gap_left <= $urandom_range(1, 40);
						else
							gap_left <= $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_tick <= 0;
			rx_hold <= 0;
		end else begin
			rx_tick <= rx_tick + 1;
			case (rx_tick[9:8])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= ($urandom_range(0, 1) == 1);
				2'd2: begin
					if (rx_hold != 0) begin
						rx_hold <= rx_hold - 1;
						m_tready <= 1'b0;
					end else begin
						m_tready <= 1'b1;
						if ($urandom_range(0, 7) == 0)
							rx_hold <= $urandom_range(1, 30);
					end
				end
				default: m_tready <= (rx_tick % 3 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin : watch
			res_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", 0, 0);
			end else begin
				want = expected_results.pop_front();
				compare_field("draw", m_tuser, want.draw);
				compare_field("line_x0", longint'($signed(m_tdata[15:0])), want.x0);
				compare_field("line_y0", longint'($signed(m_tdata[31:16])), want.y0);
				compare_field("line_x1", longint'($signed(m_tdata[47:32])), want.x1);
				compare_field("line_y1", longint'($signed(m_tdata[63:48])), want.y1);
				compare_field("cur_x", longint'($signed(m_tdata[87:64])), want.cx);
				compare_field("cur_y", longint'($signed(m_tdata[111:88])), want.cy);
				compare_field("cur_heading", longint'(m_tdata[128:112]), want.hd);
				compare_field("pen_is_down", m_tdata[129], want.pen);
				compare_field("pad bits", longint'(m_tdata[135:130]), 0);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n ||
				(s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cmd_queue.size() == 0 && !s_tvalid && expected_results.size() == 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("turtle_graphics_engine_top_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_cmd(tge_pkg::OP_QUERY, 0, 0, 0);
		add_cmd(tge_pkg::OP_FORWARD, 24'sd2560, 0, 0);
		add_cmd(tge_pkg::OP_PEN_DOWN, 0, 0, 0);
		add_cmd(tge_pkg::OP_FORWARD, 24'sd25600, 0, 0);
		add_cmd(tge_pkg::OP_RIGHT, 24'sd23040, 0, 0);
		add_cmd(tge_pkg::OP_FORWARD, 24'sd1920, 0, 0);
		add_cmd(tge_pkg::OP_LEFT, AMT_MAX, 0, 0);
		add_cmd(tge_pkg::OP_RIGHT, AMT_MIN, 0, 0);
		add_cmd(tge_pkg::OP_SET_POS, 24'sd46080, -24'sd1357, 24'sd768);
		add_cmd(tge_pkg::OP_BACK, 24'sd1000, 0, 0);
		add_cmd(tge_pkg::OP_SET_POS, 24'sd69120, AMT_MAX, AMT_MIN);
		add_cmd(tge_pkg::OP_FORWARD, AMT_MAX, 0, 0);
		add_cmd(tge_pkg::OP_SET_POS, -24'sd1, 0, 0);
		add_cmd(tge_pkg::OP_FORWARD, AMT_MAX, 0, 0);
		add_cmd(tge_pkg::OP_BACK, AMT_MIN, 0, 0);
		add_cmd(tge_pkg::OP_FORWARD, AMT_MIN, 0, 0);
		add_cmd(tge_pkg::OP_SET_POS, 24'sd92160, AMT_MIN, AMT_MAX);
		add_cmd(tge_pkg::OP_BACK, AMT_MAX, 0, 0);
		add_cmd(tge_pkg::OP_PEN_UP, 0, 0, 0);
		add_cmd(tge_pkg::OP_BACK, 24'sd256, 0, 0);
		add_cmd(tge_pkg::OP_HOME, 0, 0, 0);
		add_cmd(tge_pkg::OP_SET_POS, 24'sd11520, -24'sd300, 24'sd200);
		add_cmd(tge_pkg::OP_FORWARD, 24'sd25600, 0, 0);
		add_cmd(OP_SPARE_LO, 24'sd1234, 24'sd55, 24'sd66);
		add_cmd(OP_SPARE_HI, AMT_MIN, AMT_MAX, AMT_MIN);
		for (int n = 0; n < ITEMS_PER_RUN; n++)
			cmd_queue.push_back(rand_cmd());
		wait_idle();

		for (int ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: begin
					write_reg(tge_pkg::REG_SCREEN_WIDTH, 15'd1);
					write_reg(tge_pkg::REG_SCREEN_HEIGHT, 15'd1);
					write_reg(REG_SPARE, 15'($urandom));
				end
				2: begin
					write_reg(tge_pkg::REG_SCREEN_WIDTH, 15'd32767);
					write_reg(tge_pkg::REG_SCREEN_HEIGHT, 15'd32767);
				end
				3: begin
					write_reg(tge_pkg::REG_SCREEN_WIDTH, 15'd32767);
					write_reg(tge_pkg::REG_SCREEN_HEIGHT, 15'd1);
				end
				4: begin
					write_reg(tge_pkg::REG_SCREEN_WIDTH, 15'd2);
					write_reg(tge_pkg::REG_SCREEN_HEIGHT, 15'd32766);
					write_reg(REG_SPARE, 15'd32767);
				end
				default: begin
					write_reg(tge_pkg::REG_SCREEN_WIDTH, 15'($urandom_range(1, 32767)));
					write_reg(tge_pkg::REG_SCREEN_HEIGHT, 15'($urandom_range(1, 32767)));
				end
			endcase
			@(negedge clk);
			add_cmd(tge_pkg::OP_HOME, 0, 0, 0);
			for (int n = 0; n < ITEMS_PER_RUN; n++)
				cmd_queue.push_back(rand_cmd());
			wait_idle();
		end

		repeat (40) @(negedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never delivered", 0, expected_results.size());
		if (err_count == 0)
			$display("turtle_graphics_engine_top_tb: clean");
		else
			$display("turtle_graphics_engine_top_tb: errors");
		$finish;
	end

endmodule
